### rtl/tplc_pkg.sv
// Shared types, codes and constants of the two-point linear calibration unit.
`default_nettype none

package tplc_pkg;

   // Default channel count and fixed-point constants.
   localparam int DEF_NUM_CHANNELS = 8;
   localparam logic [31:0] GAIN_ONE = 32'd16777216;
   localparam logic [30:0] MIN_SPAN_RESET = 31'd65536;

   // Stream payload widths.
   localparam int REQ_DATA_W = 136;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 168;

   // Request tdata field positions, lowest bit first.
   localparam int REQ_CHAN_LSB = 0;
   localparam int REQ_RAW_LSB = 8;
   localparam int REQ_REF_LSB = 40;
   localparam int REQ_GAIN_LSB = 72;
   localparam int REQ_OFF_LSB = 104;

   // Command codes carried in the request tuser.
   typedef enum logic [2:0] {
      MODE_APPLY     = 3'd0,
      MODE_SET       = 3'd1,
      MODE_RESET_CH  = 3'd2,
      MODE_RESET_ALL = 3'd3,
      MODE_ONE_POINT = 3'd4,
      MODE_CAPTURE   = 3'd5,
      MODE_SOLVE     = 3'd6,
      MODE_CLEAR     = 3'd7
   } mode_type;

   // Error codes returned with each result.
   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_CHANNEL = 3'd1,
      ERR_NO_LOW  = 3'd2,
      ERR_SPAN    = 3'd3,
      ERR_GAIN    = 3'd4
   } err_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ABS,
      ST_CHECK,
      ST_DIV,
      ST_QUOT,
      ST_MUL,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

### rtl/two_point_linear_calibration_unit.sv
// Top level of the two-point linear calibration unit: sequencer, divider and RAMs.
//
//   Channel  Direction  Handshake          Payload
//   req      in         tvalid / tready    tdata: command operands, tuser: mode
//   rsp      out        tvalid / tready    tdata: result and channel readback
//   csr      in         wr_en              wr_data: min_raw_span
//
// Set, reset, capture and clear go from load straight to the result register; apply and
// one-point calibration pass through the multiplier first, and a two-point solve runs
// abs, check, a radix-2 restoring divider that produces one quotient bit per cycle,
// the quotient check and the multiplier before the result register.
// Reset is synchronous; valid bits clear all coefficients at once, so there is no
// clearing pass. A stalled result holds the sequencer in its last state.
`default_nettype none

module two_point_linear_calibration_unit
   import tplc_pkg::*;
#(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration write port.
   input  wire logic                  csr_wr_en,
   input  wire logic [30:0]           csr_wr_data,
   // Request stream.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: channel[7:0], raw[39:8], reference[71:40], gain_in[103:72],
   // offset_in[135:104]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: mode[2:0]
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   // Response stream.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: value[31:0], ok[32], error_code[35:33], gain_out[67:36],
   // offset_out[99:68], is_default[100], pending_out[101], low_raw_out[133:102],
   // low_ref_out[165:134], zero fill[167:166]
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CH_W = $clog2(NUM_CHANNELS > 1 ? NUM_CHANNELS : 2);

   // Control registers.
   state_type                 state_ff, state_in;
   logic [NUM_CHANNELS-1:0]   coef_vld_ff, coef_vld_in;
   logic [NUM_CHANNELS-1:0]   pend_ff, pend_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [30:0]               min_span_ff, min_span_in;

   // Item and datapath registers.
   mode_type                  mode_ff, mode_in;
   logic [7:0]                chan_ff, chan_in;
   logic [31:0]               raw_ff, raw_in;
   logic [31:0]               ref_ff, ref_in;
   logic [31:0]               gin_ff, gin_in;
   logic [31:0]               oin_ff, oin_in;
   err_type                   err_ff, err_in;
   logic [32:0]               span_ff, span_in;
   logic [32:0]               dref_ff, dref_in;
   logic [32:0]               span_abs_ff, span_abs_in;
   logic [32:0]               dref_abs_ff, dref_abs_in;
   logic                      span_neg_ff, span_neg_in;
   logic                      dref_neg_ff, dref_neg_in;
   logic [32:0]               rem_ff, rem_in;
   logic [31:0]               quo_ff, quo_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [31:0]               ng_ff, ng_in;
   logic signed [63:0]        prod_ff, prod_in;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   // RAM ports.
   logic                      coef_we;
   logic [63:0]               coef_wd;
   logic [63:0]               coef_rd;
   logic                      low_we;
   logic [63:0]               low_rd;
   logic                      req_fire;
   logic [CH_W-1:0]           rd_idx;

   // Channel state as seen by the current item.
   logic                      good;
   logic [CH_W-1:0]           idx;
   logic [31:0]               cur_g, cur_o, cur_lr, cur_lf;
   logic                      cur_pend;

   // Divider step, multiplier and final arithmetic.
   logic [33:0]               div_shift;
   logic [34:0]               div_trial;
   logic                      q_neg;
   logic signed [31:0]        mul_a, mul_b;
   logic [39:0]               prod_sh;
   logic [40:0]               sum_apply, diff_one, diff_solve;

   // Result of the commit step.
   logic                      rsp_free, commit;
   logic [31:0]               fin_value;
   err_type                   fin_err;
   logic                      fin_ok;
   logic [31:0]               rb_g, rb_o, rb_lr, rb_lf;
   logic                      rb_pend, rb_default, low_new;
   logic                      coef_wr, low_wr, vld_clr, pend_set, pend_clr, clr_all;

   // True when a 41-bit sum fits in a signed 32-bit word.
   function automatic logic fits32(input logic [40:0] x);
      return (x[40:31] == '0) || (x[40:31] == '1);
   endfunction

   // Clamp a 41-bit sum to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic [40:0] x);
      logic [31:0] r;
      if (fits32(x)) begin
         r = x[31:0];
      end else if (x[40]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   // Coefficient RAM holds {offset, gain}, low-point RAM holds {reference, raw}.
   tplc_ram #(
      .WIDTH (64),
      .DEPTH (NUM_CHANNELS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (idx),
      .wr_data (coef_wd),
      .rd_en   (req_fire),
      .rd_addr (rd_idx),
      .rd_data (coef_rd)
   );

   tplc_ram #(
      .WIDTH (64),
      .DEPTH (NUM_CHANNELS)
   ) u_low_ram (
      .clock   (clock),
      .wr_en   (low_we),
      .wr_addr (idx),
      .wr_data ({ref_ff, raw_ff}),
      .rd_en   (req_fire),
      .rd_addr (rd_idx),
      .rd_data (low_rd)
   );

   // Handshakes.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rd_idx     = req_tdata[REQ_CHAN_LSB +: CH_W];
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign commit     = (state_ff == ST_FIN) && rsp_free;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Current channel view; an entry without its valid bit reads as reset value.
   assign good     = {1'b0, chan_ff} < 9'(NUM_CHANNELS);
   assign idx      = chan_ff[CH_W-1:0];
   assign cur_g    = coef_vld_ff[idx] ? coef_rd[31:0] : GAIN_ONE;
   assign cur_o    = coef_vld_ff[idx] ? coef_rd[63:32] : 32'd0;
   assign cur_lr   = low_rd[31:0];
   assign cur_lf   = low_rd[63:32];
   assign cur_pend = pend_ff[idx];

   // One restoring divide step on the shifted partial remainder.
   assign div_shift = {rem_ff, quo_ff[31]};
   assign div_trial = {1'b0, div_shift} - {2'b0, span_abs_ff};
   assign q_neg     = span_neg_ff ^ dref_neg_ff;

   // Shared multiplier: gain times raw, or solved gain times low raw.
   assign mul_a = (mode_ff == MODE_SOLVE) ? $signed(ng_ff) : $signed(cur_g);
   assign mul_b = (mode_ff == MODE_SOLVE) ? $signed(cur_lr) : $signed(raw_ff);

   // The arithmetic shift of the exact product rounds toward minus infinity.
   assign prod_sh    = prod_ff[63:24];
   assign sum_apply  = {prod_sh[39], prod_sh} + {{9{cur_o[31]}}, cur_o};
   assign diff_one   = {{9{ref_ff[31]}}, ref_ff} - {prod_sh[39], prod_sh};
   assign diff_solve = {{9{cur_lf[31]}}, cur_lf} - {prod_sh[39], prod_sh};

   // Outcome of the item and the channel readback after it.
   always_comb begin
      fin_value = 32'd0;
      fin_err   = ERR_NONE;
      rb_g      = cur_g;
      rb_o      = cur_o;
      rb_pend   = cur_pend;
      low_new   = 1'b0;
      coef_wr   = 1'b0;
      coef_wd   = {cur_o, cur_g};
      low_wr    = 1'b0;
      vld_clr   = 1'b0;
      pend_set  = 1'b0;
      pend_clr  = 1'b0;
      clr_all   = 1'b0;
      if (!good && mode_ff != MODE_RESET_ALL) begin
         fin_err = ERR_CHANNEL;
         if (mode_ff == MODE_APPLY) begin
            fin_value = raw_ff;
         end
      end else begin
         unique case (mode_ff)
            MODE_APPLY: begin
               fin_value = sat32(sum_apply);
            end
            MODE_SET: begin
               if (gin_ff == 32'd0) begin
                  fin_err = ERR_GAIN;
               end else begin
                  coef_wr = 1'b1;
                  coef_wd = {oin_ff, gin_ff};
                  rb_g    = gin_ff;
                  rb_o    = oin_ff;
               end
            end
            MODE_RESET_CH: begin
               vld_clr  = 1'b1;
               pend_clr = 1'b1;
               rb_g     = GAIN_ONE;
               rb_o     = 32'd0;
               rb_pend  = 1'b0;
            end
            MODE_RESET_ALL: begin
               clr_all = 1'b1;
               rb_g    = GAIN_ONE;
               rb_o    = 32'd0;
               rb_pend = 1'b0;
            end
            MODE_ONE_POINT: begin
               if (!fits32(diff_one)) begin
                  fin_err = ERR_GAIN;
               end else begin
                  coef_wr = 1'b1;
                  coef_wd = {diff_one[31:0], cur_g};
                  rb_o    = diff_one[31:0];
               end
            end
            MODE_CAPTURE: begin
               low_wr   = 1'b1;
               pend_set = 1'b1;
               rb_pend  = 1'b1;
               low_new  = 1'b1;
            end
            MODE_SOLVE: begin
               if (err_ff != ERR_NONE) begin
                  fin_err = err_ff;
               end else if (!fits32(diff_solve)) begin
                  fin_err = ERR_GAIN;
               end else begin
                  coef_wr  = 1'b1;
                  coef_wd  = {diff_solve[31:0], ng_ff};
                  pend_clr = 1'b1;
                  rb_g     = ng_ff;
                  rb_o     = diff_solve[31:0];
                  rb_pend  = 1'b0;
               end
            end
            MODE_CLEAR: begin
               pend_clr = 1'b1;
               rb_pend  = 1'b0;
            end
         endcase
      end
      // A channel outside the table reads back as a default channel.
      if (!good) begin
         rb_g    = GAIN_ONE;
         rb_o    = 32'd0;
         rb_pend = 1'b0;
      end
      rb_lr      = rb_pend ? (low_new ? raw_ff : cur_lr) : 32'd0;
      rb_lf      = rb_pend ? (low_new ? ref_ff : cur_lf) : 32'd0;
      rb_default = (rb_g == GAIN_ONE) && (rb_o == 32'd0);
      fin_ok     = (fin_err == ERR_NONE);
   end

   assign coef_we = commit && coef_wr;
   assign low_we  = commit && low_wr;

   // Sequencer: next state and datapath next values.
   always_comb begin
      state_in      = state_ff;
      coef_vld_in   = coef_vld_ff;
      pend_in       = pend_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      min_span_in   = min_span_ff;
      mode_in       = mode_ff;
      chan_in       = chan_ff;
      raw_in        = raw_ff;
      ref_in        = ref_ff;
      gin_in        = gin_ff;
      oin_in        = oin_ff;
      err_in        = err_ff;
      span_in       = span_ff;
      dref_in       = dref_ff;
      span_abs_in   = span_abs_ff;
      dref_abs_in   = dref_abs_ff;
      span_neg_in   = span_neg_ff;
      dref_neg_in   = dref_neg_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      ng_in         = ng_ff;
      prod_in       = prod_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      // Configuration is written whenever the enable is high.
      if (csr_wr_en) begin
         min_span_in = csr_wr_data;
      end

      // A waiting result leaves once it is taken.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in  = mode_type'(req_tuser);
               chan_in  = req_tdata[REQ_CHAN_LSB +: 8];
               raw_in   = req_tdata[REQ_RAW_LSB +: 32];
               ref_in   = req_tdata[REQ_REF_LSB +: 32];
               gin_in   = req_tdata[REQ_GAIN_LSB +: 32];
               oin_in   = req_tdata[REQ_OFF_LSB +: 32];
               err_in   = ERR_NONE;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // RAM data is valid now; form both differences for a solve.
            span_in = {raw_ff[31], raw_ff} - {cur_lr[31], cur_lr};
            dref_in = {ref_ff[31], ref_ff} - {cur_lf[31], cur_lf};
            if (!good) begin
               state_in = ST_FIN;
            end else if (mode_ff == MODE_APPLY || mode_ff == MODE_ONE_POINT) begin
               state_in = ST_MUL;
            end else if (mode_ff == MODE_SOLVE) begin
               state_in = ST_ABS;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_ABS: begin
            span_neg_in = span_ff[32];
            dref_neg_in = dref_ff[32];
            span_abs_in = span_ff[32] ? (33'd0 - span_ff) : span_ff;
            dref_abs_in = dref_ff[32] ? (33'd0 - dref_ff) : dref_ff;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            // The quotient needs more than 32 bits when the dividend's upper
            // part already reaches the divisor.
            priority if (!cur_pend) begin
               err_in   = ERR_NO_LOW;
               state_in = ST_FIN;
            end else if (span_abs_ff == 33'd0 || span_abs_ff < {2'b0, min_span_ff}) begin
               err_in   = ERR_SPAN;
               state_in = ST_FIN;
            end else if ({8'd0, dref_abs_ff[32:8]} >= span_abs_ff) begin
               err_in   = ERR_GAIN;
               state_in = ST_FIN;
            end else begin
               rem_in   = {8'd0, dref_abs_ff[32:8]};
               quo_in   = {dref_abs_ff[7:0], 24'd0};
               cnt_in   = 5'd31;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_trial[34] ? div_shift[32:0] : div_trial[32:0];
            quo_in = {quo_ff[30:0], ~div_trial[34]};
            if (cnt_ff == 5'd0) begin
               state_in = ST_QUOT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_QUOT: begin
            // Zero gain and a gain outside the signed word are both unusable.
            if (quo_ff == 32'd0) begin
               err_in   = ERR_GAIN;
               state_in = ST_FIN;
            end else if (quo_ff[31] && (!q_neg || quo_ff[30:0] != 31'd0)) begin
               err_in   = ERR_GAIN;
               state_in = ST_FIN;
            end else begin
               ng_in    = q_neg ? (32'd0 - quo_ff) : quo_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, rb_lf, rb_lr, rb_pend, rb_default, rb_o, rb_g,
                                fin_err, fin_ok, fin_value};
               if (clr_all) begin
                  coef_vld_in = '0;
                  pend_in     = '0;
               end else begin
                  if (vld_clr) begin
                     coef_vld_in[idx] = 1'b0;
                  end else if (coef_wr) begin
                     coef_vld_in[idx] = 1'b1;
                  end
                  if (pend_clr) begin
                     pend_in[idx] = 1'b0;
                  end else if (pend_set) begin
                     pend_in[idx] = 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers set to their reset values by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff   <= '0;
         pend_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
         min_span_ff   <= MIN_SPAN_RESET;
      end else begin
         coef_vld_ff   <= coef_vld_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         min_span_ff   <= min_span_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      chan_ff      <= chan_in;
      raw_ff       <= raw_in;
      ref_ff       <= ref_in;
      gin_ff       <= gin_in;
      oin_ff       <= oin_in;
      err_ff       <= err_in;
      span_ff      <= span_in;
      dref_ff      <= dref_in;
      span_abs_ff  <= span_abs_in;
      dref_abs_ff  <= dref_abs_in;
      span_neg_ff  <= span_neg_in;
      dref_neg_ff  <= dref_neg_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      ng_ff        <= ng_in;
      prod_ff      <= prod_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

`default_nettype wire

### rtl/tplc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tplc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
